/* design/mdag_pkg.sv */
// Shared types, codes and width helpers for the array address generator.
// No dependencies; imported by every module of the block.
package mdag_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_ARRAYS = 16;
   localparam int DEF_MAX_DIMS   = 8;
   localparam int DEF_ADDR_WIDTH = 32;

   // Fixed field widths on the ports, and the cap on the internal arithmetic width.
   localparam int REQ_OP_W     = 2;
   localparam int REQ_ID_W     = 4;
   localparam int REQ_POS_W    = 4;
   localparam int REQ_VALUE_W  = 32;
   localparam int REQ_TDATA_W  = 72;
   localparam int RSP_ADDR_W   = 32;
   localparam int RSP_TDATA_W  = 40;
   localparam int MAX_CALC_W   = 32;

   // Op codes carried in req_tuser.
   localparam logic [REQ_OP_W-1:0] OP_HEADER = 2'd0;
   localparam logic [REQ_OP_W-1:0] OP_BOUNDS = 2'd1;
   localparam logic [REQ_OP_W-1:0] OP_QUERY  = 2'd2;

   // Command kind as it travels through the queue.
   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_BOUNDS = 2'd1,
      KIND_QUERY  = 2'd2
   } kind_type;

   // Index width for a table of n entries, never below one bit.
   function automatic int bits_for(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

/* design/mdag_front.sv */
// Front end: decodes a request beat, wraps the array id, clamps the
// dimension count and drops beats with no effect. Uses mdag_pkg.
module mdag_front
   import mdag_pkg::*;
#(
   parameter int MAX_ARRAYS = DEF_MAX_ARRAYS,
   parameter int MAX_DIMS   = DEF_MAX_DIMS,
   parameter int CALC_W     = MAX_CALC_W,
   parameter int ID_W       = bits_for(MAX_ARRAYS),
   parameter int POS_W      = bits_for(MAX_DIMS + 1),
   parameter int ITEM_W     = REQ_OP_W + REQ_ID_W + ID_W + POS_W + 2 * CALC_W
) (
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [REQ_OP_W-1:0]    req_op,
   input  logic [REQ_ID_W-1:0]    req_array_id,
   input  logic [REQ_POS_W-1:0]   req_dim_pos,
   input  logic [REQ_VALUE_W-1:0] req_value_a,
   input  logic [REQ_VALUE_W-1:0] req_value_b,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic [ITEM_W-1:0]      push_item
);

   localparam logic [REQ_POS_W:0] DIMS_LIM = (REQ_POS_W + 1)'(MAX_DIMS);

   logic [ID_W-1:0]  id_map [2**REQ_ID_W];
   logic             keep;
   kind_type         kind;
   logic [POS_W-1:0] pos_field;
   logic [REQ_POS_W:0] pos_ext;

   // raw id -> descriptor slot (id modulo MAX_ARRAYS), constant per entry
   for (genvar g = 0; g < 2**REQ_ID_W; g++) begin : g_id_map
      assign id_map[g] = ID_W'(g % MAX_ARRAYS);
   end

   assign pos_ext = {1'b0, req_dim_pos};

   always_comb begin
      keep      = 1'b0;
      kind      = KIND_QUERY;
      pos_field = '0;
      case (req_op)
         OP_HEADER: begin
            keep = 1'b1;
            kind = KIND_HEADER;
            if (req_dim_pos == '0) begin
               pos_field = POS_W'(1);
            end else if (pos_ext > DIMS_LIM) begin
               pos_field = POS_W'(MAX_DIMS);
            end else begin
               pos_field = POS_W'(req_dim_pos);
            end
         end
         OP_BOUNDS: begin
            // dimension numbers past the table are dropped
            keep      = (pos_ext < DIMS_LIM);
            kind      = KIND_BOUNDS;
            pos_field = POS_W'(req_dim_pos);
         end
         OP_QUERY: begin
            keep = 1'b1;
            kind = KIND_QUERY;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // unused op codes are still taken, just never queued
   assign req_ready  = push_ready;
   assign push_valid = req_valid && keep;
   assign push_item  = {kind, req_array_id, id_map[req_array_id], pos_field,
                        CALC_W'(req_value_a), CALC_W'(req_value_b)};

endmodule

/* design/mdag_queue.sv */
// Two-entry queue between front and back end.
// Uses mdag_pkg only for the default of its generic payload width.
module mdag_queue
   import mdag_pkg::*;
#(
   parameter int ITEM_W = REQ_TDATA_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [ITEM_W-1:0] push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [ITEM_W-1:0] pop_item
);

   logic [ITEM_W-1:0] slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/mdag_back.sv */
// Back end: descriptor and bounds tables, offset multiply-accumulate,
// final address multiply and the result register. Uses mdag_pkg.
module mdag_back
   import mdag_pkg::*;
#(
   parameter int MAX_ARRAYS = DEF_MAX_ARRAYS,
   parameter int MAX_DIMS   = DEF_MAX_DIMS,
   parameter int CALC_W     = MAX_CALC_W,
   parameter int ID_W       = bits_for(MAX_ARRAYS),
   parameter int POS_W      = bits_for(MAX_DIMS + 1),
   parameter int ITEM_W     = REQ_OP_W + REQ_ID_W + ID_W + POS_W + 2 * CALC_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  logic [ITEM_W-1:0]     q_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RSP_ADDR_W-1:0] rsp_address,
   output logic [REQ_ID_W-1:0]   rsp_query_array
);

   localparam int K_W    = bits_for(MAX_DIMS);
   localparam int SLOTS  = MAX_ARRAYS * MAX_DIMS;
   localparam int SLOT_W = bits_for(SLOTS);
   localparam logic [SLOT_W-1:0] DIM_STRIDE = SLOT_W'(MAX_DIMS);

   localparam int A_LSB    = CALC_W;
   localparam int POS_LSB  = 2 * CALC_W;
   localparam int ID_LSB   = POS_LSB + POS_W;
   localparam int RAW_LSB  = ID_LSB + ID_W;
   localparam int KIND_LSB = RAW_LSB + REQ_ID_W;

   typedef enum logic [2:0] {
      ST_FETCH = 3'b001,
      ST_MAC   = 3'b010,
      ST_ADDR  = 3'b100
   } state_type;

   // tables
   logic [CALC_W-1:0] base_mem_ff  [MAX_ARRAYS];
   logic [CALC_W-1:0] esz_mem_ff   [MAX_ARRAYS];
   logic [POS_W-1:0]  dims_mem_ff  [MAX_ARRAYS];
   logic [CALC_W-1:0] lo_mem_ff    [SLOTS];
   logic [CALC_W-1:0] hi_mem_ff    [SLOTS];

   logic [CALC_W-1:0] base_rd_ff, esz_rd_ff, lo_rd_ff, hi_rd_ff;
   logic [POS_W-1:0]  dims_rd_ff;

   state_type         state_ff, state_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [CALC_W-1:0] off_ff, off_in;
   logic [CALC_W-1:0] acc_ff, acc_in;
   logic [CALC_W-1:0] cur_a_ff, cur_a_in;
   logic [REQ_ID_W-1:0] cur_raw_ff, cur_raw_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [REQ_ID_W-1:0]   rsp_id_ff, rsp_id_in;

   // queue item fields
   kind_type            it_kind;
   logic [REQ_ID_W-1:0] it_raw;
   logic [ID_W-1:0]     it_id;
   logic [POS_W-1:0]    it_pos;
   logic [CALC_W-1:0]   it_a, it_b;

   logic              hdr_we, bnd_we, rd_en;
   logic [SLOT_W-1:0] wr_slot, rd_slot;
   logic [CALC_W-1:0] extent, acc_src, mac, addr_calc;
   logic              last_dim;

   assign it_b    = q_item[CALC_W-1:0];
   assign it_a    = q_item[A_LSB +: CALC_W];
   assign it_pos  = q_item[POS_LSB +: POS_W];
   assign it_id   = q_item[ID_LSB +: ID_W];
   assign it_raw  = q_item[RAW_LSB +: REQ_ID_W];
   assign it_kind = kind_type'(q_item[KIND_LSB +: 2]);

   assign wr_slot = SLOT_W'(it_id) * DIM_STRIDE + SLOT_W'(K_W'(it_pos));
   assign rd_slot = SLOT_W'(it_id) * DIM_STRIDE + SLOT_W'(k_ff);

   // offset step: off * extent + (index - lower), first dimension starts at 0
   assign extent   = hi_rd_ff - lo_rd_ff + CALC_W'(1);
   assign acc_src  = (k_ff == '0) ? '0 : off_ff;
   assign mac      = acc_src * extent + (cur_a_ff - lo_rd_ff);
   assign last_dim = ((POS_W + 1)'(k_ff) + (POS_W + 1)'(1)) >= {1'b0, dims_rd_ff};

   // final address from the registered offset
   assign addr_calc = base_rd_ff + acc_ff * esz_rd_ff;

   assign q_ready         = (state_ff == ST_FETCH);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_address     = rsp_addr_ff;
   assign rsp_query_array = rsp_id_ff;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      off_in       = off_ff;
      acc_in       = acc_ff;
      cur_a_in     = cur_a_ff;
      cur_raw_in   = cur_raw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_id_in    = rsp_id_ff;
      hdr_we       = 1'b0;
      bnd_we       = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         ST_FETCH: begin
            if (q_valid) begin
               case (it_kind)
                  KIND_HEADER: hdr_we = 1'b1;
                  KIND_BOUNDS: bnd_we = 1'b1;
                  KIND_QUERY: begin
                     rd_en      = 1'b1;
                     cur_a_in   = it_a;
                     cur_raw_in = it_raw;
                     state_in   = ST_MAC;
                  end
                  default: ;
               endcase
            end
         end
         ST_MAC: begin
            acc_in = mac;
            if (last_dim) begin
               k_in     = '0;
               off_in   = '0;
               state_in = ST_ADDR;
            end else begin
               k_in     = k_ff + K_W'(1);
               off_in   = mac;
               state_in = ST_FETCH;
            end
         end
         ST_ADDR: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = RSP_ADDR_W'(addr_calc);
               rsp_id_in    = cur_raw_ff;
               state_in     = ST_FETCH;
            end
         end
         default: state_in = ST_FETCH;
      endcase
   end

   // table writes and registered reads
   always_ff @(posedge clock) begin
      if (hdr_we) begin
         base_mem_ff[it_id] <= it_a;
         esz_mem_ff[it_id]  <= it_b;
         dims_mem_ff[it_id] <= it_pos;
      end
      if (bnd_we) begin
         lo_mem_ff[wr_slot] <= it_a;
         hi_mem_ff[wr_slot] <= it_b;
      end
      if (rd_en) begin
         base_rd_ff <= base_mem_ff[it_id];
         esz_rd_ff  <= esz_mem_ff[it_id];
         dims_rd_ff <= dims_mem_ff[it_id];
         lo_rd_ff   <= lo_mem_ff[rd_slot];
         hi_rd_ff   <= hi_mem_ff[rd_slot];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      cur_a_ff    <= cur_a_in;
      cur_raw_ff  <= cur_raw_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_id_ff   <= rsp_id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         k_ff         <= '0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/multidim_array_address_generator_top.sv */
// Top level of the row-major array address generator.
// Depends on mdag_pkg, mdag_front, mdag_queue and mdag_back.
//
// Holds up to MAX_ARRAYS array descriptors (base, element size, dimension
// count) and MAX_DIMS lower/upper bounds per array. Request beats carry the
// op in req_tuser: op 0 writes a descriptor header (dim_pos = dimension
// count, 0 taken as 1, counts above MAX_DIMS taken as MAX_DIMS), op 1 writes
// the bounds of dimension dim_pos (ignored when dim_pos >= MAX_DIMS), op 2
// delivers the next index of a query, and op 3 is dropped. Each index folds
// into a running offset, offset = offset * (upper - lower + 1) +
// (index - lower); the index that completes the descriptor's dimension
// count produces one response beat with base + offset * element_size and
// the array id of that beat. Arithmetic wraps at ADDR_WIDTH bits (at most
// 32 reach the port; narrower widths are zero-extended). Bounds are not
// checked. The tables come up undefined after reset with no clearing pass;
// an entry must be written before a query reads it. Writes land in beat
// order, so a header or bounds write between indices affects the rest of
// that query. The front end takes a beat per cycle, while the two-entry
// queue has room; the back end retires a header or bounds beat in its
// fetch state, a non-final index through a registered table read and
// then the offset multiply-accumulate, and a final index through both of
// those plus the address multiply-add into the response register, which
// waits while a previous result is held and rsp_tready is low.
module multidim_array_address_generator_top
   import mdag_pkg::*;
#(
   parameter int MAX_ARRAYS = DEF_MAX_ARRAYS,
   parameter int MAX_DIMS   = DEF_MAX_DIMS,
   parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [3:0] array_id, [7:4] dim_pos, [39:8] value_a, [71:40] value_b
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] op
   input  logic [REQ_OP_W-1:0]    req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] address, [35:32] query_array, [39:36] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // only the low 32 bits of the wrapped result reach the port
   localparam int CALC_W = (ADDR_WIDTH < MAX_CALC_W) ? ADDR_WIDTH : MAX_CALC_W;
   localparam int ID_W   = bits_for(MAX_ARRAYS);
   localparam int POS_W  = bits_for(MAX_DIMS + 1);
   localparam int ITEM_W = REQ_OP_W + REQ_ID_W + ID_W + POS_W + 2 * CALC_W;

   logic                  push_valid, push_ready;
   logic [ITEM_W-1:0]     push_item;
   logic                  pop_valid, pop_ready;
   logic [ITEM_W-1:0]     pop_item;
   logic [RSP_ADDR_W-1:0] rsp_address;
   logic [REQ_ID_W-1:0]   rsp_query_array;

   mdag_front #(
      .MAX_ARRAYS (MAX_ARRAYS),
      .MAX_DIMS   (MAX_DIMS),
      .CALC_W     (CALC_W),
      .ID_W       (ID_W),
      .POS_W      (POS_W),
      .ITEM_W     (ITEM_W)
   ) u_front (
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (req_tuser),
      .req_array_id (req_tdata[3:0]),
      .req_dim_pos  (req_tdata[7:4]),
      .req_value_a  (req_tdata[39:8]),
      .req_value_b  (req_tdata[71:40]),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_item    (push_item)
   );

   mdag_queue #(
      .ITEM_W (ITEM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   mdag_back #(
      .MAX_ARRAYS (MAX_ARRAYS),
      .MAX_DIMS   (MAX_DIMS),
      .CALC_W     (CALC_W),
      .ID_W       (ID_W),
      .POS_W      (POS_W),
      .ITEM_W     (ITEM_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (pop_valid),
      .q_ready         (pop_ready),
      .q_item          (pop_item),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_address     (rsp_address),
      .rsp_query_array (rsp_query_array)
   );

   assign rsp_tdata = {4'b0000, rsp_query_array, rsp_address};

endmodule

/* tb/mdag_checker.sv */
// Checker for the array address generator: watches both stream channels,
// predicts every response beat and compares it. Depends on mdag_pkg.
module mdag_checker
   import mdag_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_OP_W-1:0]    req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     fail_count,
   output int                     pending
);

   localparam int SLOTS = DEF_MAX_ARRAYS * DEF_MAX_DIMS;

   // descriptor tables, mirrored from the request stream
   logic [31:0] base_mem  [DEF_MAX_ARRAYS];
   logic [31:0] esize_mem [DEF_MAX_ARRAYS];
   int          dims_mem  [DEF_MAX_ARRAYS];
   logic [31:0] lo_mem    [SLOTS];
   logic [31:0] hi_mem    [SLOTS];

   // running query
   logic [31:0] run_offset;
   int          run_dim;

   // addresses still owed by the block, oldest first
   logic [31:0] owed_addr_q [$];
   logic [3:0]  owed_id_q   [$];

   always @(posedge clock) begin : watch
      logic [REQ_OP_W-1:0] op;
      logic [3:0]          id;
      logic [3:0]          pos;
      logic [31:0]         val_a;
      logic [31:0]         val_b;
      logic [31:0]         extent;
      logic [31:0]         acc;
      logic [31:0]         want_addr;
      logic [3:0]          want_id;
      int                  k;
      int                  slot;
      if (reset) begin
         run_offset = '0;
         run_dim    = 0;
         fail_count = 0;
         pending    = 0;
         owed_addr_q.delete();
         owed_id_q.delete();
      end else begin
         // response side first: a beat accepted now cannot stem from a
         // request accepted at this same edge
         if (rsp_tvalid && rsp_tready) begin
            if (owed_addr_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected none, actual addr %h id %h",
                        $time, rsp_tdata[31:0], rsp_tdata[35:32]);
            end else begin
               want_addr = owed_addr_q.pop_front();
               want_id   = owed_id_q.pop_front();
               if (rsp_tdata[31:0] !== want_addr) begin
                  fail_count++;
                  $display("%0t: address mismatch, expected %h, actual %h",
                           $time, want_addr, rsp_tdata[31:0]);
               end
               if (rsp_tdata[35:32] !== want_id) begin
                  fail_count++;
                  $display("%0t: query_array mismatch, expected %h, actual %h",
                           $time, want_id, rsp_tdata[35:32]);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            op    = req_tuser;
            id    = req_tdata[3:0];
            pos   = req_tdata[7:4];
            val_a = req_tdata[39:8];
            val_b = req_tdata[71:40];
            case (op)
               OP_HEADER: begin
                  base_mem[id]  = val_a;
                  esize_mem[id] = val_b;
                  dims_mem[id]  = (pos == 0) ? 1 :
                                  (pos > DEF_MAX_DIMS) ? DEF_MAX_DIMS : int'(pos);
               end
               OP_BOUNDS: begin
                  if (pos < DEF_MAX_DIMS) begin
                     slot         = int'(id) * DEF_MAX_DIMS + int'(pos);
                     lo_mem[slot] = val_a;
                     hi_mem[slot] = val_b;
                  end
               end
               OP_QUERY: begin
                  k = (run_dim >= DEF_MAX_DIMS) ? DEF_MAX_DIMS - 1 : run_dim;
                  slot   = int'(id) * DEF_MAX_DIMS + k;
                  extent = hi_mem[slot] - lo_mem[slot] + 32'd1;
                  acc    = (k == 0) ? 32'd0 : run_offset;
                  acc    = acc * extent + (val_a - lo_mem[slot]);
                  if (k + 1 >= dims_mem[id]) begin
                     owed_addr_q.push_back(base_mem[id] + acc * esize_mem[id]);
                     owed_id_q.push_back(id);
                     run_offset = '0;
                     run_dim    = 0;
                  end else begin
                     run_offset = acc;
                     run_dim    = k + 1;
                  end
               end
               default: ;  // unused op, dropped by the block
            endcase
         end
         pending = owed_addr_q.size();
      end
   end

endmodule

/* tb/testbench.sv */
// Top of the array address generator testbench: clock, reset, request
// stimulus, response back-pressure and the verdict.
// Depends on mdag_pkg, mdag_checker and multidim_array_address_generator_top.
module testbench;
   import mdag_pkg::*;

   localparam int MAX_ARRAYS   = DEF_MAX_ARRAYS;
   localparam int MAX_DIMS     = DEF_MAX_DIMS;
   localparam int SLOTS        = MAX_ARRAYS * MAX_DIMS;
   localparam int RANDOM_BEATS = 1800;
   localparam int CYCLE_LIMIT  = 400_000;
   // spare cycles to wait once no response is owed any more
   localparam int DRAIN_CYCLES = 10;

   // op 3 has no meaning in the block; it is only sent as noise
   localparam logic [REQ_OP_W-1:0] OP_UNUSED = 2'd3;

   // receiver back-pressure styles
   localparam int READY_ALWAYS    = 0;
   localparam int READY_RANDOM    = 1;
   localparam int READY_ALTERNATE = 2;
   localparam int READY_LONG_HOLD = 3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [3:0] array_id, [7:4] dim_pos, [39:8] value_a, [71:40] value_b
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // [1:0] op
   logic [REQ_OP_W-1:0]    req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [31:0] address, [35:32] query_array, [39:36] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int fail_count;
   int pending;
   int cycle_count = 0;

   multidim_array_address_generator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mdag_checker u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case a beat is lost or the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: switches at random between back-pressure styles so stalls
   // land on every phase of the response path, including stretches where
   // it never stalls.
   // ------------------------------------------------------------------
   int stall_mode = READY_ALWAYS;
   int mode_left  = 0;
   int hold_left  = 0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(READY_ALWAYS, READY_LONG_HOLD);
         mode_left  = $urandom_range(40, 200);
      end
      mode_left--;
      case (stall_mode)
         READY_ALWAYS:    rsp_tready = 1'b1;
         READY_RANDOM:    rsp_tready = ($urandom_range(0, 3) != 0);
         READY_ALTERNATE: rsp_tready = ~rsp_tready;
         default: begin
            // long low stretches broken by short high windows
            if (hold_left <= 0) begin
               rsp_tready = ~rsp_tready;
               hold_left  = rsp_tready ? $urandom_range(1, 4) : $urandom_range(4, 20);
            end
            hold_left--;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Sender bookkeeping. This is only what stimulus needs to stay legal:
   // which descriptors and bounds have been written (the tables are
   // undefined until then), the dimension counts, and where the running
   // query stands, so every index reads written entries.
   // ------------------------------------------------------------------
   bit          hdr_ok  [MAX_ARRAYS];
   int          ndims   [MAX_ARRAYS];
   bit          bnd_ok  [SLOTS];
   logic [31:0] bnd_lo  [SLOTS];
   logic [31:0] bnd_hi  [SLOTS];
   int          qk         = 0;   // dimension the next index lands on
   int          burst_left = 0;
   int          live_beats = 0;   // beats the block acts on

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // One request beat. Called on a falling edge, returns on the falling
   // edge after the beat was taken. Bursts of back-to-back beats alternate
   // with idle gaps of random length.
   task automatic send_beat(input logic [REQ_OP_W-1:0] op, input logic [3:0] id,
                            input logic [3:0] pos, input logic [31:0] val_a,
                            input logic [31:0] val_b);
      int gap;
      int slot;
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 15) : $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {val_b, val_a, pos, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;

      slot = int'(id) * MAX_DIMS + int'(pos);
      case (op)
         OP_HEADER: begin
            hdr_ok[id] = 1'b1;
            ndims[id]  = (pos == 0) ? 1 : (pos > MAX_DIMS) ? MAX_DIMS : int'(pos);
         end
         OP_BOUNDS: begin
            if (pos < MAX_DIMS) begin
               bnd_ok[slot] = 1'b1;
               bnd_lo[slot] = val_a;
               bnd_hi[slot] = val_b;
            end
         end
         OP_QUERY: qk = (qk + 1 >= ndims[id]) ? 0 : qk + 1;
         default: ;
      endcase
      if (!(op == OP_UNUSED || (op == OP_BOUNDS && pos >= MAX_DIMS)))
         live_beats++;
   endtask

   // Mostly small windows so in-range indices are easy to hit; now and
   // then full-range bounds, which also gives upper < lower.
   task automatic write_bounds(input int id, input int pos);
      logic [31:0] lo;
      logic [31:0] hi;
      if ($urandom_range(0, 4) == 0) begin
         lo = rand_word();
         hi = rand_word();
      end else begin
         lo = $urandom_range(0, 20) - 10;
         hi = lo + $urandom_range(0, 7);
      end
      send_beat(OP_BOUNDS, id[3:0], pos[3:0], lo, hi);
   endtask

   task automatic write_header(input int id, input int pos);
      logic [31:0] base;
      logic [31:0] esize;
      base = ($urandom_range(0, 3) == 0) ? rand_word() : $urandom;
      case ($urandom_range(0, 9))
         0:       esize = rand_word();
         1:       esize = 32'd1;
         2:       esize = 32'd2;
         3:       esize = 32'd3;
         4:       esize = 32'd8;
         5:       esize = 32'd16;
         default: esize = 32'd4;
      endcase
      send_beat(OP_HEADER, id[3:0], pos[3:0], base, esize);
   endtask

   // Header followed by the bounds of each dimension; now and then some
   // dimensions are left out and get written just before use, if unwritten.
   task automatic define_array();
      int id;
      int pos;
      int d;
      id = $urandom_range(0, MAX_ARRAYS - 1);
      case ($urandom_range(0, 9))
         0:       pos = 0;                        // taken as one dimension
         1:       pos = $urandom_range(9, 15);    // clamped to MAX_DIMS
         default: pos = $urandom_range(1, MAX_DIMS);
      endcase
      write_header(id, pos);
      for (d = 0; d < ndims[id]; d++)
         if ($urandom_range(0, 9) != 0)
            write_bounds(id, d);
   endtask

   // One full query: indices until the block closes it. Along the way a
   // few header or bounds writes slip in, and some indices name another
   // defined array, which the block treats as part of the same query.
   task automatic run_query();
      int          qid;
      int          cur;
      int          pick;
      int          slot;
      int          r;
      logic [31:0] span;
      logic [31:0] idx;
      qid = -1;
      for (pick = 0; pick < 16 && qid < 0; pick++) begin
         cur = $urandom_range(0, MAX_ARRAYS - 1);
         if (hdr_ok[cur])
            qid = cur;
      end
      if (qid < 0) begin
         define_array();
         return;
      end
      do begin
         r = $urandom_range(0, 99);
         if (r < 4)
            write_header($urandom_range(0, MAX_ARRAYS - 1), $urandom_range(1, MAX_DIMS));
         else if (r < 10)
            write_bounds($urandom_range(0, MAX_ARRAYS - 1), $urandom_range(0, MAX_DIMS - 1));
         cur = qid;
         if (r >= 90) begin
            pick = $urandom_range(0, MAX_ARRAYS - 1);
            if (hdr_ok[pick])
               cur = pick;
         end
         slot = cur * MAX_DIMS + qk;
         if (!bnd_ok[slot])
            write_bounds(cur, qk);
         span = bnd_hi[slot] - bnd_lo[slot];
         // in range plus one past the top, else anything at all
         if ($urandom_range(0, 9) == 0 || span > 64)
            idx = rand_word();
         else
            idx = bnd_lo[slot] + $urandom_range(0, span + 1);
         send_beat(OP_QUERY, cur[3:0], 4'($urandom_range(0, 15)), idx, rand_word());
      end while (qk != 0);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int p;
      int goal;
      int sel;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed part ---
      // array 0: zero dims taken as one, extremes in base and size, and a
      // bound pair whose extent wraps to zero
      send_beat(OP_HEADER, 4'd0, 4'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_beat(OP_BOUNDS, 4'd0, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_beat(OP_BOUNDS, 4'd0, 4'd3, 32'h0000_0000, 32'h0000_0000);
      send_beat(OP_QUERY,  4'd0, 4'd0, 32'hFFFF_FFFF, 32'h0000_0000);
      // array 15: dimension count above the maximum, all dims bounded,
      // last one with upper below lower
      send_beat(OP_HEADER, 4'd15, 4'd15, 32'h8000_0000, 32'd4);
      for (p = 0; p < MAX_DIMS; p++)
         send_beat(OP_BOUNDS, 4'd15, p[3:0],
                   (p == 0) ? 32'hFFFF_FFFF : (p == 6) ? 32'h8000_0000 :
                   (p == 7) ? 32'd5 : p,
                   (p == 0) ? 32'd2 : (p == 6) ? 32'h7FFF_FFFF :
                   (p == 7) ? 32'd2 : p + 3);
      // dimension number out of range and the unused op: both dropped
      send_beat(OP_BOUNDS, 4'd15, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(OP_UNUSED, 4'd9, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // three indices into array 15, out-of-bounds values among them,
      // then an index naming array 0, whose single dimension is already
      // passed, which closes the query
      send_beat(OP_QUERY, 4'd15, 4'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_beat(OP_QUERY, 4'd15, 4'd0, 32'h8000_0000, 32'h0000_0000);
      send_beat(OP_QUERY, 4'd15, 4'd0, 32'd4, 32'd0);
      send_beat(OP_QUERY, 4'd0, 4'd0, 32'd0, 32'd0);
      // header rewritten between indices: the query ends on the new count
      send_beat(OP_QUERY,  4'd15, 4'd0, 32'd1, 32'd0);
      send_beat(OP_HEADER, 4'd15, 4'd2, 32'h0000_0100, 32'h0000_0010);
      send_beat(OP_QUERY,  4'd15, 4'd0, 32'd2, 32'd0);

      // --- random part ---
      goal = live_beats + RANDOM_BEATS;
      while (live_beats < goal) begin
         sel = $urandom_range(0, 99);
         if (sel < 55)
            run_query();
         else if (sel < 85)
            define_array();
         else begin
            case ($urandom_range(0, 3))
               0: send_beat(OP_UNUSED, 4'($urandom_range(0, 15)),
                            4'($urandom_range(0, 15)), rand_word(), rand_word());
               1: send_beat(OP_BOUNDS, 4'($urandom_range(0, 15)),
                            4'($urandom_range(MAX_DIMS, 15)), rand_word(), rand_word());
               2: write_bounds($urandom_range(0, MAX_ARRAYS - 1),
                               $urandom_range(0, MAX_DIMS - 1));
               default: write_header($urandom_range(0, MAX_ARRAYS - 1),
                                     $urandom_range(0, 15));
            endcase
         end
      end
      req_tvalid = 1'b0;

      // --- drain and verdict ---
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* filelist.f */
design/mdag_pkg.sv
design/mdag_front.sv
design/mdag_queue.sv
design/mdag_back.sv
design/multidim_array_address_generator_top.sv
tb/mdag_checker.sv
tb/testbench.sv
